// File: hw/rtl/tfn_pkg.sv
// Package for the triangle face normal pipeline: widths, item types and stage buses.
`default_nettype none
package tfn_pkg;

    localparam int COORD_WIDTH      = 16;
    localparam int NORMAL_FRAC_BITS = 14;

    localparam int FIELD_W   = 16;
    localparam int OUT_W     = 16;
    localparam int DIFF_W    = COORD_WIDTH + 1;
    localparam int PROD_W    = 2 * DIFF_W;
    localparam int CROSS_W   = PROD_W + 1;
    localparam int NORM_BITS = 30;
    localparam int LEN_W     = $clog2(CROSS_W + 1);
    localparam int SQ_W      = 2 * NORM_BITS;
    localparam int SUM_W     = SQ_W + 2;
    localparam int ROOT_W    = SUM_W / 2;
    localparam int REM_W     = ROOT_W + 2;
    localparam int QUO_W     = NORMAL_FRAC_BITS + 1;
    localparam int DIVD_W    = NORM_BITS + NORMAL_FRAC_BITS + 1;

    localparam logic [QUO_W-1:0] Q_ONE = QUO_W'(1) << NORMAL_FRAC_BITS;

    typedef struct packed {
        logic signed [FIELD_W-1:0] a_x;
        logic signed [FIELD_W-1:0] a_y;
        logic signed [FIELD_W-1:0] a_z;
        logic signed [FIELD_W-1:0] b_x;
        logic signed [FIELD_W-1:0] b_y;
        logic signed [FIELD_W-1:0] b_z;
        logic signed [FIELD_W-1:0] c_x;
        logic signed [FIELD_W-1:0] c_y;
        logic signed [FIELD_W-1:0] c_z;
    } t_in_item;

    typedef struct packed {
        logic signed [OUT_W-1:0] normal_x;
        logic signed [OUT_W-1:0] normal_y;
        logic signed [OUT_W-1:0] normal_z;
        logic                    degenerate;
    } t_out_item;

    typedef struct packed {
        logic [2:0][NORM_BITS-1:0] sm;
        logic [2:0]                neg;
        logic                      degen;
    } t_lane_pay;

    typedef struct packed {
        logic             valid;
        logic [SUM_W-1:0] sum;
        t_lane_pay        pay;
    } t_root_bus;

    typedef struct packed {
        logic              valid;
        logic [ROOT_W-1:0] root;
        t_lane_pay         pay;
    } t_len_bus;

endpackage
`default_nettype wire

// File: hw/rtl/triangle_face_normal.sv
// Throughput: one triangle per cycle while the skid entry is empty; 7 front stages,
//   31 square-root stages (one root bit each), 17 divider stages (dividend set-up
//   with round-off, one stage per quotient bit for 15 bits, then saturation, sign
//   and fallback) and an output stage.
// Reset: synchronous, active low; clears all valid bits and the skid entry,
//   so the block is empty and ready when reset is released.
`default_nettype none
module triangle_face_normal import tfn_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_item  i_item,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_item
);

    // The whole pipeline advances together; it holds only while the skid entry is full.
    logic      w_adv;
    t_root_bus w_root_bus;
    t_len_bus  w_len_bus;
    logic      w_pv;
    t_out_item w_pitem;

    logic      r_out_v;
    t_out_item r_out;
    logic      r_skid_v;
    t_out_item r_skid;

    assign w_adv   = !r_skid_v;
    assign o_ready = w_adv;

    // Cross product, alignment to a 30-bit top and sum of squares
    tfn_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (i_valid),
        .i_item  (i_item),
        .o_bus   (w_root_bus)
    );

    // Length as the floor of the square root
    tfn_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_bus   (w_root_bus),
        .o_bus   (w_len_bus)
    );

    // Scale each lane by the length, round, saturate, apply sign and fallback
    tfn_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_bus   (w_len_bus),
        .o_valid (w_pv),
        .o_item  (w_pitem)
    );

    // Output register with a skid entry behind it: while a result waits, the next item
    // from the pipeline parks in the skid entry and input closes until it drains.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_skid_v) begin
            if (!r_out_v || i_ready) begin
                r_out_v <= w_pv;
            end else if (w_pv) begin
                r_skid_v <= 1'b1;
            end
        end else if (i_ready) begin
            // drain the skid entry into the output register
            r_skid_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_skid_v) begin
            if (!r_out_v || i_ready) begin
                r_out <= w_pitem;
            end else begin
                r_skid <= w_pitem;
            end
        end else if (i_ready) begin
            r_out <= r_skid;
        end
    end

    assign o_valid = r_out_v;
    assign o_item  = r_out;

endmodule
`default_nettype wire

// File: hw/rtl/tfn_front.sv
// Front stages: differences, products, cross product, alignment and sum of squares.
`default_nettype none
module tfn_front import tfn_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_en,
    input  logic      i_valid,
    input  t_in_item  i_item,
    output t_root_bus o_bus
);

    localparam int STAGES = 7;

    function automatic logic signed [DIFF_W-1:0] ext(input logic [FIELD_W-1:0] f);
        return DIFF_W'(signed'(f[COORD_WIDTH-1:0]));
    endfunction

    logic [STAGES-1:0] r_vld;

    logic signed [DIFF_W-1:0]  n_u [3], n_v [3], r_u [3], r_v [3];
    logic signed [PROD_W-1:0]  n_p [6], r_p [6];
    logic signed [CROSS_W-1:0] w_m [3];
    logic [CROSS_W-1:0]        n_mag3 [3], r_mag3 [3], r_mag4 [3];
    logic [2:0]                n_neg3, r_neg3, r_neg4, r_neg5, r_neg6, r_neg7;
    logic [CROSS_W-1:0]        w_or;
    logic [LEN_W-1:0]          n_len, r_len;
    logic                      n_dg4, r_dg4, r_dg5, r_dg6, r_dg7;
    logic [LEN_W-1:0]          w_sh;
    logic [CROSS_W-1:0]        w_al [3];
    logic [2:0][NORM_BITS-1:0] n_sm5, r_sm5, r_sm6, r_sm7;
    logic [SQ_W-1:0]           n_sq [3], r_sq [3];
    logic [SUM_W-1:0]          n_sum, r_sum;

    always_comb begin
        n_u[0] = ext(i_item.a_x) - ext(i_item.b_x);
        n_u[1] = ext(i_item.a_y) - ext(i_item.b_y);
        n_u[2] = ext(i_item.a_z) - ext(i_item.b_z);
        n_v[0] = ext(i_item.b_x) - ext(i_item.c_x);
        n_v[1] = ext(i_item.b_y) - ext(i_item.c_y);
        n_v[2] = ext(i_item.b_z) - ext(i_item.c_z);

        n_p[0] = r_u[1] * r_v[2];
        n_p[1] = r_u[2] * r_v[1];
        n_p[2] = r_u[2] * r_v[0];
        n_p[3] = r_u[0] * r_v[2];
        n_p[4] = r_u[0] * r_v[1];
        n_p[5] = r_u[1] * r_v[0];

        for (int i = 0; i < 3; i++) begin
            w_m[i]    = r_p[2*i] - r_p[2*i+1];
            n_neg3[i] = w_m[i][CROSS_W-1];
            n_mag3[i] = n_neg3[i] ? CROSS_W'(-w_m[i]) : CROSS_W'(w_m[i]);
        end

        // bit length of the largest magnitude
        w_or  = r_mag3[0] | r_mag3[1] | r_mag3[2];
        n_len = '0;
        for (int i = 0; i < CROSS_W; i++) begin
            if (w_or[i]) begin
                n_len = LEN_W'(i + 1);
            end
        end
        n_dg4 = (w_or == '0);

        // bring the top bit to NORM_BITS-1 with one shift for all lanes
        w_sh = LEN_W'(CROSS_W) - r_len;
        for (int i = 0; i < 3; i++) begin
            w_al[i]  = r_mag4[i] << w_sh;
            n_sm5[i] = w_al[i][CROSS_W-1 -: NORM_BITS];
            n_sq[i]  = r_sm5[i] * r_sm5[i];
        end

        n_sum = SUM_W'(r_sq[0]) + SUM_W'(r_sq[1]) + SUM_W'(r_sq[2]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[STAGES-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_u    <= n_u;
            r_v    <= n_v;
            r_p    <= n_p;
            r_mag3 <= n_mag3;
            r_neg3 <= n_neg3;
            r_mag4 <= r_mag3;
            r_neg4 <= r_neg3;
            r_len  <= n_len;
            r_dg4  <= n_dg4;
            r_sm5  <= n_sm5;
            r_neg5 <= r_neg4;
            r_dg5  <= r_dg4;
            r_sq   <= n_sq;
            r_sm6  <= r_sm5;
            r_neg6 <= r_neg5;
            r_dg6  <= r_dg5;
            r_sum  <= n_sum;
            r_sm7  <= r_sm6;
            r_neg7 <= r_neg6;
            r_dg7  <= r_dg6;
        end
    end

    assign o_bus.valid     = r_vld[STAGES-1];
    assign o_bus.sum       = r_sum;
    assign o_bus.pay.sm    = r_sm7;
    assign o_bus.pay.neg   = r_neg7;
    assign o_bus.pay.degen = r_dg7;

endmodule
`default_nettype wire

// File: hw/rtl/tfn_sqrt.sv
// Integer square root, one result bit per pipeline stage.
`default_nettype none
module tfn_sqrt import tfn_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_en,
    input  t_root_bus i_bus,
    output t_len_bus  o_bus
);

    logic                r_vld  [ROOT_W];
    logic [REM_W-1:0]    r_rem  [ROOT_W];
    logic [ROOT_W-1:0]   r_root [ROOT_W];
    logic [SUM_W-1:0]    r_rest [ROOT_W];
    t_lane_pay           r_pay  [ROOT_W];

    logic                a_vld  [ROOT_W];
    logic [REM_W-1:0]    a_rem  [ROOT_W];
    logic [ROOT_W-1:0]   a_root [ROOT_W];
    logic [SUM_W-1:0]    a_rest [ROOT_W];
    t_lane_pay           a_pay  [ROOT_W];

    logic [REM_W-1:0]    n_rem  [ROOT_W];
    logic [ROOT_W-1:0]   n_root [ROOT_W];
    logic [SUM_W-1:0]    n_rest [ROOT_W];

    logic [REM_W+1:0]    w_rs   [ROOT_W];
    logic [REM_W+1:0]    w_tr   [ROOT_W];
    logic                w_ge   [ROOT_W];

    always_comb begin
        a_vld[0]  = i_bus.valid;
        a_rem[0]  = '0;
        a_root[0] = '0;
        a_rest[0] = i_bus.sum;
        a_pay[0]  = i_bus.pay;
        for (int k = 1; k < ROOT_W; k++) begin
            a_vld[k]  = r_vld[k-1];
            a_rem[k]  = r_rem[k-1];
            a_root[k] = r_root[k-1];
            a_rest[k] = r_rest[k-1];
            a_pay[k]  = r_pay[k-1];
        end
        for (int k = 0; k < ROOT_W; k++) begin
            w_rs[k]   = {a_rem[k], a_rest[k][SUM_W-1 -: 2]};
            w_tr[k]   = (REM_W + 2)'({a_root[k], 2'b01});
            w_ge[k]   = (w_rs[k] >= w_tr[k]);
            n_rem[k]  = w_ge[k] ? REM_W'(w_rs[k] - w_tr[k]) : REM_W'(w_rs[k]);
            n_root[k] = {a_root[k][ROOT_W-2:0], w_ge[k]};
            n_rest[k] = a_rest[k] << 2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < ROOT_W; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (i_en) begin
            r_vld <= a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_root <= n_root;
            r_rest <= n_rest;
            r_pay  <= a_pay;
        end
    end

    assign o_bus.valid = r_vld[ROOT_W-1];
    assign o_bus.root  = r_root[ROOT_W-1];
    assign o_bus.pay   = r_pay[ROOT_W-1];

endmodule
`default_nettype wire

// File: hw/rtl/tfn_div.sv
// Three-lane pipelined restoring divider with rounding, saturation, sign and fallback.
`default_nettype none
module tfn_div import tfn_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_en,
    input  t_len_bus  i_bus,
    output logic      o_valid,
    output t_out_item o_item
);

    logic                        r_pv;
    logic [2:0][ROOT_W-1:0]      r_prem;
    logic [2:0][QUO_W-1:0]       r_plow;
    logic [ROOT_W-1:0]           r_pl;
    logic [2:0]                  r_pneg;
    logic                        r_pdg;
    logic [2:0][DIVD_W-1:0]      w_num;

    logic                        r_vld [QUO_W];
    logic [2:0][ROOT_W-1:0]      r_rem [QUO_W];
    logic [2:0][QUO_W-1:0]       r_q   [QUO_W];
    logic [ROOT_W-1:0]           r_l   [QUO_W];
    logic [2:0]                  r_neg [QUO_W];
    logic                        r_dg  [QUO_W];

    logic                        a_vld [QUO_W];
    logic [2:0][ROOT_W-1:0]      a_rem [QUO_W];
    logic [2:0][QUO_W-1:0]       a_q   [QUO_W];
    logic [ROOT_W-1:0]           a_l   [QUO_W];
    logic [2:0]                  a_neg [QUO_W];
    logic                        a_dg  [QUO_W];

    logic [2:0][ROOT_W-1:0]      n_rem [QUO_W];
    logic [2:0][QUO_W-1:0]       n_q   [QUO_W];
    logic [ROOT_W:0]             w_r2;
    logic                        w_ge;

    logic                        r_fv;
    t_out_item                   r_fin;
    t_out_item                   n_fin;
    logic [QUO_W-1:0]            w_sat [3];
    logic signed [OUT_W-1:0]     w_mag [3];
    logic signed [OUT_W-1:0]     w_val [3];

    always_comb begin
        // dividend carries the half-divisor for round half away from zero
        for (int i = 0; i < 3; i++) begin
            w_num[i] = DIVD_W'({i_bus.pay.sm[i], NORMAL_FRAC_BITS'(0)})
                     + DIVD_W'(i_bus.root >> 1);
        end

        a_vld[0] = r_pv;
        a_rem[0] = r_prem;
        a_q[0]   = r_plow;
        a_l[0]   = r_pl;
        a_neg[0] = r_pneg;
        a_dg[0]  = r_pdg;
        for (int k = 1; k < QUO_W; k++) begin
            a_vld[k] = r_vld[k-1];
            a_rem[k] = r_rem[k-1];
            a_q[k]   = r_q[k-1];
            a_l[k]   = r_l[k-1];
            a_neg[k] = r_neg[k-1];
            a_dg[k]  = r_dg[k-1];
        end

        w_r2 = '0;
        w_ge = 1'b0;
        for (int k = 0; k < QUO_W; k++) begin
            for (int i = 0; i < 3; i++) begin
                w_r2 = {a_rem[k][i], a_q[k][i][QUO_W-1]};
                w_ge = (w_r2 >= {1'b0, a_l[k]});
                n_rem[k][i] = w_ge ? ROOT_W'(w_r2 - {1'b0, a_l[k]}) : ROOT_W'(w_r2);
                n_q[k][i]   = {a_q[k][i][QUO_W-2:0], w_ge};
            end
        end

        for (int i = 0; i < 3; i++) begin
            w_sat[i] = (r_q[QUO_W-1][i] > Q_ONE) ? Q_ONE : r_q[QUO_W-1][i];
            w_mag[i] = OUT_W'(w_sat[i]);
            w_val[i] = r_neg[QUO_W-1][i] ? -w_mag[i] : w_mag[i];
        end
        if (r_dg[QUO_W-1]) begin
            n_fin.normal_x   = OUT_W'(Q_ONE);
            n_fin.normal_y   = '0;
            n_fin.normal_z   = '0;
            n_fin.degenerate = 1'b1;
        end else begin
            n_fin.normal_x   = w_val[0];
            n_fin.normal_y   = w_val[1];
            n_fin.normal_z   = w_val[2];
            n_fin.degenerate = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
            r_fv <= 1'b0;
            for (int k = 0; k < QUO_W; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (i_en) begin
            r_pv  <= i_bus.valid;
            r_vld <= a_vld;
            r_fv  <= r_vld[QUO_W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_prem[i] <= ROOT_W'(w_num[i][DIVD_W-1:QUO_W]);
                r_plow[i] <= w_num[i][QUO_W-1:0];
            end
            r_pl   <= i_bus.root;
            r_pneg <= i_bus.pay.neg;
            r_pdg  <= i_bus.pay.degen;
            r_rem  <= n_rem;
            r_q    <= n_q;
            r_l    <= a_l;
            r_neg  <= a_neg;
            r_dg   <= a_dg;
            r_fin  <= n_fin;
        end
    end

    assign o_valid = r_fv;
    assign o_item  = r_fin;

endmodule
`default_nettype wire

// File: hw/rtl/tfn_checker.sv
// Port-level checker for the face normal block, bound to the top level.
`default_nettype none
module tfn_checker import tfn_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_ready,
    input logic      o_valid,
    input logic      i_ready,
    input t_out_item o_item
);

    localparam logic signed [OUT_W-1:0] ONE = OUT_W'(Q_ONE);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && o_ready)
        else $error("block not empty after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_item))
        else $error("stalled result item changed");

    a_full_means_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid)
        else $error("input closed with no result waiting");

    a_fallback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item.degenerate |->
            o_item.normal_x == ONE && o_item.normal_y == '0 && o_item.normal_z == '0)
        else $error("degenerate item without fallback vector");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_item.normal_x <= ONE && o_item.normal_x >= -ONE
                 && o_item.normal_y <= ONE && o_item.normal_y >= -ONE
                 && o_item.normal_z <= ONE && o_item.normal_z >= -ONE)
        else $error("normal component out of range");

endmodule

bind triangle_face_normal tfn_checker u_tfn_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_ready (o_ready),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_item  (o_item)
);
`default_nettype wire

// File: tb/triangle_face_normal_test.sv
// Self-checking testbench for the triangle face normal pipeline.
module triangle_face_normal_test;
    import tfn_pkg::*;

    localparam int LATENCY = 56;
    localparam int MAX_SHOWN = 10;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_ready;
    t_in_item  i_item;
    logic      o_valid;
    logic      i_ready;
    t_out_item o_item;

    // pending triangles, expected normals
    t_in_item  tri_queue[$];
    t_out_item normal_queue[$];

    int  error_count;
    int  send_idle_pct;
    int  recv_stall_pct;
    bit  send_hold;

    triangle_face_normal u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_item  (o_item)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Integer square root, floor, of a value below 2^62.
    function automatic longint unsigned floor_root(longint unsigned s);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > s) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (s >= root + bitv) begin
                s = s - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // Unit normal of (a-b) x (b-c), scaled to Q1.F with fallback on zero length.
    function automatic t_out_item face_normal(t_in_item t);
        logic signed [63:0] ux, uy, uz, vx, vy, vz;
        logic signed [63:0] m [3];
        logic [63:0] mag [3];
        logic [63:0] sm [3];
        bit neg [3];
        int maxlen;
        longint unsigned s, len, q, one;
        logic [OUT_W-1:0] comp [3];
        t_out_item r;
        ux = 64'(t.a_x) - 64'(t.b_x);
        uy = 64'(t.a_y) - 64'(t.b_y);
        uz = 64'(t.a_z) - 64'(t.b_z);
        vx = 64'(t.b_x) - 64'(t.c_x);
        vy = 64'(t.b_y) - 64'(t.c_y);
        vz = 64'(t.b_z) - 64'(t.c_z);
        // products fit easily in 64 bits for 17-bit differences
        m[0] = uy * vz - uz * vy;
        m[1] = uz * vx - ux * vz;
        m[2] = ux * vy - uy * vx;
        one = 64'd1 << NORMAL_FRAC_BITS;
        maxlen = 0;
        for (int i = 0; i < 3; i++) begin
            neg[i] = m[i] < 0;
            mag[i] = neg[i] ? -m[i] : m[i];
            for (int b = 0; b < 64; b++)
                if (mag[i][b] && b + 1 > maxlen) maxlen = b + 1;
        end
        if (maxlen == 0) begin
            r.normal_x = OUT_W'(one);
            r.normal_y = '0;
            r.normal_z = '0;
            r.degenerate = 1'b1;
            return r;
        end
        s = 0;
        for (int i = 0; i < 3; i++) begin
            if (maxlen > NORM_BITS) sm[i] = mag[i] >> (maxlen - NORM_BITS);
            else sm[i] = mag[i] << (NORM_BITS - maxlen);
            s = s + sm[i] * sm[i];
        end
        len = floor_root(s);
        for (int i = 0; i < 3; i++) begin
            q = ((sm[i] << NORMAL_FRAC_BITS) + (len >> 1)) / len;
            if (q > one) q = one;
            comp[i] = neg[i] ? OUT_W'(-q) : OUT_W'(q);
        end
        r.normal_x = comp[0];
        r.normal_y = comp[1];
        r.normal_z = comp[2];
        r.degenerate = 1'b0;
        return r;
    endfunction

    // Driver: present the next pending triangle, hold it until accepted.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || o_ready) begin
            // drop the accepted item; the next one is then at the front
            if (i_valid) void'(tri_queue.pop_front());
            // next item goes out only when one is waiting and the sender is not idling
            if (!send_hold && tri_queue.size() > 0
                && $urandom_range(99) >= send_idle_pct) begin
                i_valid <= 1'b1;
                i_item  <= tri_queue[0];
                normal_queue.insert(normal_queue.size(), face_normal(tri_queue[0]));
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Monitor: check accepted results against the oldest expectation; stall at random.
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (normal_queue.size() == 0) begin
                    error_count++;
                    if (error_count <= MAX_SHOWN)
                        $display("unexpected result %h", o_item);
                end else begin
                    want = normal_queue.pop_front();
                    if (o_item !== want) begin
                        error_count++;
                        if (error_count <= MAX_SHOWN)
                            $display("mismatch: expected %0d %0d %0d deg %0b, got %0d %0d %0d deg %0b",
                                     want.normal_x, want.normal_y, want.normal_z, want.degenerate,
                                     o_item.normal_x, o_item.normal_y, o_item.normal_z,
                                     o_item.degenerate);
                    end
                end
            end
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic t_in_item make_tri(logic [15:0] ax, logic [15:0] ay, logic [15:0] az,
                                          logic [15:0] bx, logic [15:0] by, logic [15:0] bz,
                                          logic [15:0] cx, logic [15:0] cy, logic [15:0] cz);
        t_in_item t;
        t.a_x = ax; t.a_y = ay; t.a_z = az;
        t.b_x = bx; t.b_y = by; t.b_z = bz;
        t.c_x = cx; t.c_y = cy; t.c_z = cz;
        return t;
    endfunction

    // Random triangle; mix full range, small coordinates and degenerate shapes.
    function automatic t_in_item random_tri();
        t_in_item t;
        int kind;
        int k;
        t = 144'({$urandom, $urandom, $urandom, $urandom, $urandom});
        kind = $urandom_range(9);
        if (kind < 3) begin
            // small, local triangles near a random point
            t.b_x = t.a_x + 16'(signed'($urandom_range(64)) - 32);
            t.b_y = t.a_y + 16'(signed'($urandom_range(64)) - 32);
            t.b_z = t.a_z + 16'(signed'($urandom_range(64)) - 32);
            t.c_x = t.a_x + 16'(signed'($urandom_range(64)) - 32);
            t.c_y = t.a_y + 16'(signed'($urandom_range(64)) - 32);
            t.c_z = t.a_z + 16'(signed'($urandom_range(64)) - 32);
        end else if (kind == 3) begin
            // collinear: c = b + k*(b-a)
            k = $urandom_range(3);
            t.b_x = t.a_x + 16'($urandom_range(200)) - 16'd100;
            t.b_y = t.a_y + 16'($urandom_range(200)) - 16'd100;
            t.b_z = t.a_z + 16'($urandom_range(200)) - 16'd100;
            t.c_x = t.b_x + 16'(k) * (t.b_x - t.a_x);
            t.c_y = t.b_y + 16'(k) * (t.b_y - t.a_y);
            t.c_z = t.b_z + 16'(k) * (t.b_z - t.a_z);
        end else if (kind == 4) begin
            // axis-aligned triangle in a plane of constant z: two zero components
            t.b_z = t.a_z;
            t.c_z = t.a_z;
            if ($urandom_range(1)) t.c_y = t.b_y;
        end
        return t;
    endfunction

    // Append one triangle to the pending items.
    task automatic queue_tri(input t_in_item t);
        tri_queue.insert(tri_queue.size(), t);
    endtask

    task automatic run_phase(int idle_pct, int stall_pct, int count);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int n = 0; n < count; n++) queue_tri(random_tri());
        wait (tri_queue.size() == 0);
    endtask

    initial begin
        error_count    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_hold      = 1'b0;
        i_valid        = 1'b0;
        i_ready        = 1'b0;
        i_item         = '0;
        i_rst_n        = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, coincident and collinear corners, axis normals
        queue_tri(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0));
        queue_tri(make_tri(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
                           16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff));
        queue_tri(make_tri(0, 0, 0, 1, 1, 1, 2, 2, 2));
        queue_tri(make_tri(0, 0, 0, 1, 0, 0, 0, 1, 0));
        queue_tri(make_tri(0, 0, 0, 0, 1, 0, 0, 0, 1));
        queue_tri(make_tri(0, 0, 0, 0, 0, 1, 1, 0, 0));
        queue_tri(make_tri(16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h8000,
                           16'h8000, 16'h7fff, 16'h7fff, 16'h8000));
        queue_tri(make_tri(16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff,
                           16'h8000, 16'h7fff, 16'h7fff, 16'h8000));
        queue_tri(make_tri(16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000,
                           16'h7fff, 16'h8000, 16'h8000, 16'h7fff));
        queue_tri(make_tri(16'hffff, 16'hffff, 16'hffff, 0, 0, 0, 1, 2, 3));
        queue_tri(make_tri(1, 0, 0, 0, 0, 0, 0, 16'h7fff, 0));
        queue_tri(make_tri(16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555,
                           16'haaaa, 16'h1234, 16'hedcb, 16'h0f0f));
        queue_tri(make_tri(3, 7, 11, 3, 7, 11, 100, 200, 300));
        wait (tri_queue.size() == 0);

        // pause the sender until the pipeline has drained
        send_hold = 1'b1;
        wait (normal_queue.size() == 0);
        send_hold = 1'b0;

        run_phase(0, 0, 400);
        run_phase(63, 0, 300);
        run_phase(0, 63, 300);
        run_phase(12, 12, 400);

        wait (normal_queue.size() == 0);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Watchdog: generous fixed bound on the whole run.
    initial begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end
endmodule
